[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on the clock edge after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rgbhsv_pkg.sv]
package rgbhsv_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [16:0] sat_hsv;
    logic [7:0]  value;
    logic [16:0] sat_hsl;
    logic [8:0]  light_sum;
    logic        is_gray;
  } pix_out_t;

  localparam int unsigned HueW = 16;
  localparam int unsigned SatW = 17;
  localparam logic [8:0] HalfScale = 9'd255;
  localparam logic [9:0] FullSum = 10'd510;

endpackage

[hw/rtl/rgbhsv_div_stage.sv]
module rgbhsv_div_stage #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 11,
  parameter int unsigned RW = 12
) (
  input  logic [RW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] quo_i,
  output logic [RW-1:0] rem_o,
  output logic [NW-1:0] num_o,
  output logic [NW-1:0] quo_o
);

  logic [RW:0] trial;

  always_comb begin
    trial = {rem_i, num_i[NW-1]};
    num_o = {num_i[NW-2:0], 1'b0};
    if (trial >= {{(RW+1-DW){1'b0}}, den_i}) begin
      rem_o = RW'(trial - {{(RW+1-DW){1'b0}}, den_i});
      quo_o = {quo_i[NW-2:0], 1'b1};
    end else begin
      rem_o = trial[RW-1:0];
      quo_o = {quo_i[NW-2:0], 1'b0};
    end
  end

endmodule

[hw/rtl/rgbhsv_divider.sv]
module rgbhsv_divider #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 11,
  parameter int unsigned STEPS = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  localparam int unsigned NST = (NW + STEPS - 1) / STEPS;
  localparam int unsigned RW = DW + 1;

  logic [RW-1:0] rem_r [NST+1];
  logic [NW-1:0] num_r [NST+1];
  logic [NW-1:0] quo_r [NST+1];
  logic [DW-1:0] den_r [NST+1];
  logic [RW-1:0] rem_c [NST][STEPS+1];
  logic [NW-1:0] num_c [NST][STEPS+1];
  logic [NW-1:0] quo_c [NST][STEPS+1];

  assign rem_r[0] = '0;
  assign num_r[0] = num_i;
  assign quo_r[0] = '0;
  assign den_r[0] = den_i;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    assign rem_c[s][0] = rem_r[s];
    assign num_c[s][0] = num_r[s];
    assign quo_c[s][0] = quo_r[s];
    for (genvar k = 0; k < STEPS; k++) begin : g_step
      if (s * STEPS + k < NW) begin : g_real
        rgbhsv_div_stage #(.NW(NW), .DW(DW), .RW(RW)) u_step (
          .rem_i(rem_c[s][k]), .den_i(den_r[s]), .num_i(num_c[s][k]),
          .quo_i(quo_c[s][k]), .rem_o(rem_c[s][k+1]), .num_o(num_c[s][k+1]),
          .quo_o(quo_c[s][k+1])
        );
      end else begin : g_pad
        assign rem_c[s][k+1] = rem_c[s][k];
        assign num_c[s][k+1] = num_c[s][k];
        assign quo_c[s][k+1] = quo_c[s][k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv_i) begin
        rem_r[s+1] <= rem_c[s][STEPS];
        num_r[s+1] <= num_c[s][STEPS];
        quo_r[s+1] <= quo_c[s][STEPS];
        den_r[s+1] <= den_r[s];
      end
    end
  end

  assign quo_o = quo_r[NST];

  logic unused_ok;
  assign unused_ok = rst_n ^ (|rem_r[NST]) ^ (|num_r[NST]) ^ (|den_r[NST]);

endmodule

[hw/rtl/rgbhsv_front.sv]
module rgbhsv_front
  import rgbhsv_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  pix_in_t             pix_i,
  output logic [FRAC_BITS+10:0] hnum_o,
  output logic [10:0]         hden_o,
  output logic [FRAC_BITS+7:0] dnum_o,
  output logic [7:0]          sden_o,
  output logic [8:0]          lden_o,
  output logic [7:0]          mx_o,
  output logic [8:0]          sum_o,
  output logic                gray_o
);

  logic [7:0] r, g, b, mx, mn, d;
  logic [10:0] t;
  logic [10:0] six_d;

  always_comb begin
    r = pix_i.red;
    g = pix_i.green;
    b = pix_i.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    six_d = 11'(d) * 11'd6;
    if (r == mx) begin
      t = (g >= b) ? 11'(g - b) : 11'(six_d - 11'(b - g));
    end else if (g == mx) begin
      t = 11'({d, 1'b0}) + 11'(b) - 11'(r);
    end else begin
      t = 11'({d, 2'b0}) + 11'(r) - 11'(g);
    end
    sum_o = 9'(mx) + 9'(mn);
    lden_o = (sum_o < 9'(HalfScale)) ? sum_o : 9'(FullSum - 10'(sum_o));
    hnum_o = {t, {FRAC_BITS{1'b0}}};
    hden_o = six_d;
    dnum_o = {d, {FRAC_BITS{1'b0}}};
    sden_o = mx;
    mx_o = mx;
    gray_o = (d == 8'd0);
  end

endmodule

[hw/rtl/rgb_to_hsv_hsl_core.sv]
// RGB to HSV/HSL converter. One pixel is taken in every clock cycle while
// in_stall is low. The channel compare is registered, then three restoring
// dividers (hue, HSV and HSL saturation) resolve four quotient bits per
// register stage, then an output register follows.
// The hue divider depth, ceil((FRAC_BITS+11)/4) stages, sets the latency;
// a stall on a valid output freezes the whole pipeline without losing data.
module rgb_to_hsv_hsl_core
  import rgbhsv_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rgbhsv_pkg::pix_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rgbhsv_pkg::pix_out_t out_data
);

  localparam int unsigned STEPS = 4;
  localparam int unsigned HW = FRAC_BITS + 11;
  localparam int unsigned SW = FRAC_BITS + 8;
  localparam int unsigned NST = (HW + STEPS - 1) / STEPS;
  localparam int unsigned SNST = (SW + STEPS - 1) / STEPS;

  logic adv;
  logic [HW-1:0] hnum;
  logic [10:0] hden;
  logic [SW-1:0] dnum;
  logic [7:0] sden;
  logic [8:0] lden;
  logic [7:0] mx;
  logic [8:0] sum;
  logic gray;

  logic [HW-1:0] hnum_r;
  logic [10:0] hden_r;
  logic [SW-1:0] dnum_r;
  logic [7:0] sden_r;
  logic [8:0] lden_r;
  logic f_vld_r;

  logic [NST:0] vld_r;
  logic [7:0] mx_r [NST+1];
  logic [8:0] sum_r [NST+1];
  logic gray_r [NST+1];
  logic [HW-1:0] hq;
  logic [SW-1:0] sq, lq;
  logic [SW-1:0] sq_d [NST-SNST+1];
  logic [SW-1:0] lq_d [NST-SNST+1];
  pix_out_t out_nxt;
  pix_out_t out_r;
  logic out_vld_r;

  assign adv = !out_vld_r || !out_stall;
  assign in_stall = !adv;

  rgbhsv_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .pix_i(in_data), .hnum_o(hnum), .hden_o(hden), .dnum_o(dnum),
    .sden_o(sden), .lden_o(lden), .mx_o(mx), .sum_o(sum), .gray_o(gray)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      hnum_r <= hnum;
      hden_r <= hden;
      dnum_r <= dnum;
      sden_r <= sden;
      lden_r <= lden;
      mx_r[0] <= mx;
      sum_r[0] <= sum;
      gray_r[0] <= gray;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= in_valid;
    end
  end

  rgbhsv_divider #(.NW(HW), .DW(11), .STEPS(STEPS)) u_hue (
    .clk(clk), .rst_n(rst_n), .adv_i(adv), .num_i(hnum_r), .den_i(hden_r), .quo_o(hq)
  );
  rgbhsv_divider #(.NW(SW), .DW(8), .STEPS(STEPS)) u_shsv (
    .clk(clk), .rst_n(rst_n), .adv_i(adv), .num_i(dnum_r), .den_i(sden_r), .quo_o(sq)
  );
  rgbhsv_divider #(.NW(SW), .DW(9), .STEPS(STEPS)) u_shsl (
    .clk(clk), .rst_n(rst_n), .adv_i(adv), .num_i(dnum_r), .den_i(lden_r), .quo_o(lq)
  );

  assign sq_d[0] = sq;
  assign lq_d[0] = lq;
  for (genvar i = 0; i < NST - SNST; i++) begin : g_align
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_d[i+1] <= sq_d[i];
        lq_d[i+1] <= lq_d[i];
      end
    end
  end

  assign vld_r[0] = f_vld_r;
  for (genvar i = 0; i < NST; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        mx_r[i+1] <= mx_r[i];
        sum_r[i+1] <= sum_r[i];
        gray_r[i+1] <= gray_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
  end

  always_comb begin
    out_nxt.value = mx_r[NST];
    out_nxt.light_sum = sum_r[NST];
    out_nxt.is_gray = gray_r[NST];
    if (gray_r[NST]) begin
      out_nxt.hue = '0;
      out_nxt.sat_hsv = '0;
      out_nxt.sat_hsl = '0;
    end else begin
      out_nxt.hue = hq[HueW-1:0];
      out_nxt.sat_hsv = SatW'(sq_d[NST-SNST]);
      out_nxt.sat_hsl = SatW'(lq_d[NST-SNST]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_r[NST];
    end
  end

  assign out_valid = out_vld_r;
  assign out_data = out_r;

endmodule

[hw/rtl/rgbhsv_checker.sv]
module rgbhsv_checker
  import rgbhsv_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input rgbhsv_pkg::pix_in_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input rgbhsv_pkg::pix_out_t out_data
);

`include "assert_macros.svh"

  logic unused_in;
  assign unused_in = in_valid ^ (|in_data);

  `CHK_IMPL(a_stall_only_when_full, in_stall, out_valid && out_stall, "stall without backpressure")
  `CHK_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data), "output changed")
  `CHK_IMPL(a_gray_zero, out_valid && out_data.is_gray, out_data.hue == 16'd0 && out_data.sat_hsv == 17'd0 && out_data.sat_hsl == 17'd0, "gray chroma")
  `CHK_IMPL(a_sum_bound, out_valid, out_data.light_sum <= 9'd510 && out_data.light_sum >= 9'(out_data.value), "lightness range")

endmodule

bind rgb_to_hsv_hsl_core rgbhsv_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
